FILE: hw/rtl/assert_macros.svh
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

FILE: hw/rtl/smpq_pkg.sv
package smpq_pkg;

	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	// Operation codes on s_tuser
	localparam logic [2:0] KIND_ENQ    = 3'd0;
	localparam logic [2:0] KIND_DEQ    = 3'd1;
	localparam logic [2:0] KIND_SEARCH = 3'd2;
	localparam logic [2:0] KIND_UPDATE = 3'd3;
	localparam logic [2:0] KIND_CLEAR  = 3'd4;

	// Result status codes on m_tuser
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	// Command broadcast to every cell of the chain
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_INSERT,
		OP_REMOVE,
		OP_POP,
		OP_CLEAR
	} cell_op_t;

	typedef struct packed {
		cell_op_t            op;
		logic [DATA_W-1:0]   key;
	} cell_cmd_t;

endpackage

FILE: hw/rtl/sorted_min_priority_queue_core.sv
// Channel  Dir  tdata fields (low bit up)                          tuser
// s_*      in   value[31:0], new_value[63:32]                      kind[2:0]
// m_*      out  removed_value[31:0], position[36:32],              status[1:0]
//               front_value[68:37], occupancy[73:69],
//               empty_res[74], zero fill [79:75]
//
// Every operation makes one pass through the cell chain; an update that finds
// its old value makes two: one pass removes the entry, the next inserts the
// new value. The result is registered and s_tready stays high while it
// waits, as long as m_tready frees the output register in the same cycle.
// Reset empties the queue at once; entry contents are not cleared.
module sorted_min_priority_queue_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // value[31:0], new_value[63:32]
	input  logic [2:0]  s_tuser,   // kind[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // removed[31:0], pos[36:32], front[68:37], occ[73:69], empty[74]
	output logic [1:0]  m_tuser    // status[1:0]
);

	`include "assert_macros.svh"

	localparam int DW = smpq_pkg::DATA_W;
	localparam int CW = smpq_pkg::CNT_W;
	localparam int N  = smpq_pkg::DEPTH;

	typedef enum logic {S_IDLE, S_INSERT} state_t;

	state_t               state_q;
	logic [DW-1:0]        pend_q;
	logic [CW-1:0]        count_q;
	logic                 m_tvalid_q;
	logic [1:0]           status_q;
	logic [DW-1:0]        removed_q;
	logic [CW-1:0]        pos_q;
	logic [DW-1:0]        front_q;
	logic [CW-1:0]        occ_q;
	logic                 empty_q;

	logic [2:0]           kind;
	logic [DW-1:0]        value;
	logic [DW-1:0]        new_value;
	logic                 accept;

	smpq_pkg::cell_cmd_t  cmd;
	logic [DW-1:0]        val_vec [N];
	logic [DW-1:0]        d_val_vec [N];
	logic [N-1:0]         vld_vec;
	logic [N-1:0]         d_vld_vec;
	logic [N-1:0]         gt_vec;
	logic [N-1:0]         eq_vec;

	logic [CW-1:0]        hit_pos;
	logic                 any_eq;
	logic                 is_empty;
	logic                 is_full;
	logic                 res_fire;
	logic                 go_insert;
	logic [1:0]           status_d;
	logic [DW-1:0]        removed_d;
	logic [CW-1:0]        pos_d;
	logic [CW-1:0]        count_d;

	assign kind      = s_tuser;
	assign value     = s_tdata[31:0];
	assign new_value = s_tdata[63:32];
	assign s_tready  = (state_q == S_IDLE) && (!m_tvalid_q || m_tready);
	assign accept    = s_tvalid && s_tready;
	assign is_empty  = (count_q == '0);
	assign is_full   = (count_q == CW'(N));

	// Chain of cells, each linked to its left and right neighbors
	for (genvar i = 0; i < N; i++) begin : g_cell
		logic [DW-1:0] lv;
		logic          lvld;
		logic          lgt;
		logic [DW-1:0] rv;
		logic          rvld;
		if (i == 0) begin : g_first
			assign lv   = '0;
			assign lvld = 1'b0;
			assign lgt  = 1'b0;
		end else begin : g_mid_l
			assign lv   = val_vec[i-1];
			assign lvld = vld_vec[i-1];
			assign lgt  = gt_vec[i-1];
		end
		if (i == N - 1) begin : g_last
			assign rv   = '0;
			assign rvld = 1'b0;
		end else begin : g_mid_r
			assign rv   = val_vec[i+1];
			assign rvld = vld_vec[i+1];
		end
		smpq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.left_val  (lv),
			.left_vld  (lvld),
			.left_gt   (lgt),
			.right_val (rv),
			.right_vld (rvld),
			.val       (val_vec[i]),
			.vld       (vld_vec[i]),
			.gt        (gt_vec[i]),
			.eq        (eq_vec[i]),
			.d_val     (d_val_vec[i]),
			.d_vld     (d_vld_vec[i])
		);
	end

	// Encode the first matching cell as a 1-based position; equal entries
	// sit next to each other, so the first one has no match on its left
	always_comb begin
		hit_pos = '0;
		for (int i = 0; i < N; i++) begin
			if (eq_vec[i] && (i == 0 || !eq_vec[(i == 0) ? 0 : i-1])) begin
				hit_pos = hit_pos | CW'(i + 1);
			end
		end
	end
	assign any_eq = |eq_vec;

	// Decode the operation into a chain command and a result
	always_comb begin
		cmd.op    = smpq_pkg::OP_HOLD;
		cmd.key   = value;
		status_d  = smpq_pkg::ST_OK;
		removed_d = '0;
		pos_d     = '0;
		count_d   = count_q;
		res_fire  = 1'b0;
		go_insert = 1'b0;
		if (state_q == S_INSERT) begin
			cmd.op   = smpq_pkg::OP_INSERT;
			cmd.key  = pend_q;
			count_d  = count_q + CW'(1);
			res_fire = 1'b1;
		end else if (accept) begin
			res_fire = 1'b1;
			case (kind)
				smpq_pkg::KIND_ENQ: begin
					if (is_full) begin
						status_d = smpq_pkg::ST_FULL;
					end else begin
						cmd.op  = smpq_pkg::OP_INSERT;
						count_d = count_q + CW'(1);
					end
				end
				smpq_pkg::KIND_DEQ: begin
					if (is_empty) begin
						status_d = smpq_pkg::ST_EMPTY;
					end else begin
						cmd.op    = smpq_pkg::OP_POP;
						removed_d = val_vec[0];
						count_d   = count_q - CW'(1);
					end
				end
				smpq_pkg::KIND_SEARCH: begin
					if (is_empty) begin
						status_d = smpq_pkg::ST_EMPTY;
					end else if (any_eq) begin
						pos_d = hit_pos;
					end else begin
						status_d = smpq_pkg::ST_NOTFOUND;
					end
				end
				smpq_pkg::KIND_UPDATE: begin
					if (is_empty) begin
						status_d = smpq_pkg::ST_EMPTY;
					end else if (any_eq) begin
						cmd.op    = smpq_pkg::OP_REMOVE;
						count_d   = count_q - CW'(1);
						res_fire  = 1'b0;
						go_insert = 1'b1;
					end else begin
						status_d = smpq_pkg::ST_NOTFOUND;
					end
				end
				smpq_pkg::KIND_CLEAR: begin
					cmd.op  = smpq_pkg::OP_CLEAR;
					count_d = '0;
				end
				default: begin
					cmd.op = smpq_pkg::OP_HOLD;
				end
			endcase
		end
	end

	// Advance state, count and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			pend_q     <= '0;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
			status_q   <= '0;
			removed_q  <= '0;
			pos_q      <= '0;
			front_q    <= '0;
			occ_q      <= '0;
			empty_q    <= 1'b1;
		end else begin
			count_q <= count_d;
			case (state_q)
				S_IDLE: begin
					if (go_insert) begin
						state_q <= S_INSERT;
						pend_q  <= new_value;
					end
				end
				S_INSERT: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (res_fire) begin
				m_tvalid_q <= 1'b1;
				status_q   <= status_d;
				removed_q  <= removed_d;
				pos_q      <= pos_d;
				front_q    <= d_vld_vec[0] ? d_val_vec[0] : '0;
				occ_q      <= count_d;
				empty_q    <= (count_d == '0);
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {5'b0, empty_q, occ_q, front_q, pos_q, removed_q};

	`ASSERT_NEVER(a_count_max, clk, arst_n, count_q > CW'(N), "entry count above capacity")
	`ASSERT_PROP(a_count_cells, clk, arst_n, $countones(vld_vec) == count_q, "count disagrees with occupied cells")
	`ASSERT_NEVER(a_insert_out_busy, clk, arst_n, (state_q == S_INSERT) && m_tvalid_q, "result register busy during second update pass")
	`ASSERT_PROP(a_full_drop, clk, arst_n, (accept && kind == smpq_pkg::KIND_ENQ && is_full) |=> $stable(count_q), "enqueue on full queue changed count")

endmodule

FILE: hw/rtl/smpq_cell.sv
// One slot of the sorted chain. Compares its entry with the broadcast key
// and moves data to or from its neighbors according to the command.
module smpq_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  smpq_pkg::cell_cmd_t           cmd,
	input  logic [smpq_pkg::DATA_W-1:0]   left_val,
	input  logic                          left_vld,
	input  logic                          left_gt,
	input  logic [smpq_pkg::DATA_W-1:0]   right_val,
	input  logic                          right_vld,
	output logic [smpq_pkg::DATA_W-1:0]   val,
	output logic                          vld,
	output logic                          gt,
	output logic                          eq,
	output logic [smpq_pkg::DATA_W-1:0]   d_val,
	output logic                          d_vld
);

	logic [smpq_pkg::DATA_W-1:0] val_q;
	logic                        vld_q;
	logic                        ge;

	// Compare the stored entry with the key; an empty slot counts as larger
	assign gt = !vld_q || ($signed(val_q) > $signed(cmd.key));
	assign ge = !vld_q || ($signed(val_q) >= $signed(cmd.key));
	assign eq = vld_q && (val_q == cmd.key);

	// Select next contents: keep, take the key, take a neighbor's entry, or clear the flag
	always_comb begin
		d_val = val_q;
		d_vld = vld_q;
		case (cmd.op)
			smpq_pkg::OP_INSERT: begin
				if (gt && left_gt) begin
					d_val = left_val;
					d_vld = left_vld;
				end else if (gt) begin
					d_val = cmd.key;
					d_vld = 1'b1;
				end
			end
			smpq_pkg::OP_REMOVE: begin
				if (ge) begin
					d_val = right_val;
					d_vld = right_vld;
				end
			end
			smpq_pkg::OP_POP: begin
				d_val = right_val;
				d_vld = right_vld;
			end
			smpq_pkg::OP_CLEAR: begin
				d_vld = 1'b0;
			end
			default: begin
				d_val = val_q;
				d_vld = vld_q;
			end
		endcase
	end

	// Hold the occupied flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= d_vld;
		end
	end

	// Hold the entry
	always_ff @(posedge clk) begin
		val_q <= d_val;
	end

	assign val = val_q;
	assign vld = vld_q;

endmodule

FILE: bench/sorted_min_priority_queue_core_tb.sv
module sorted_min_priority_queue_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DATA_W = smpq_pkg::DATA_W;
	localparam int CNT_W  = smpq_pkg::CNT_W;
	localparam int DEPTH  = smpq_pkg::DEPTH;

	localparam int HALF_PERIOD = 5;
	localparam int RESET_CYCLES = 12;
	localparam int RAND_ITEMS = 500;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT = 200000;

	// Operation codes the block treats as no-ops
	localparam logic [2:0] KIND_SPARE_LO  = 3'd5;
	localparam logic [2:0] KIND_SPARE_MID = 3'd6;
	localparam logic [2:0] KIND_SPARE_HI  = 3'd7;

	localparam logic signed [DATA_W-1:0] MAXV = 32'h7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] MINV = 32'h8000_0000;

	typedef enum logic [1:0] {
		RX_STEADY,
		RX_CHOPPY,
		RX_SLUGGISH
	} rx_mode_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [DATA_W-1:0] removed;
		logic [CNT_W-1:0]  pos;
		logic [DATA_W-1:0] front;
		logic [CNT_W-1:0]  occ;
		logic              empty;
	} pq_result_t;

	typedef struct {
		logic [2:0]        kind;
		logic [DATA_W-1:0] value;
		logic [DATA_W-1:0] new_value;
		int                reps;
		bit                typed;
		pq_result_t        res;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;   // value[31:0], new_value[63:32]
	logic [2:0]  s_tuser = '0;   // kind[2:0]
	logic        m_tvalid;
	logic        m_tready = 1'b1;
	logic [79:0] m_tdata;        // removed[31:0], pos[36:32], front[68:37], occ[73:69], empty[74]
	logic [1:0]  m_tuser;        // status[1:0]

	// Shadow copy of the sorted store
	logic signed [DATA_W-1:0] shadow_vals [DEPTH];
	int shadow_count = 0;

	pq_result_t pending_results [$];
	dir_row_t   dir_rows [$];
	int err_count = 0;
	int result_idx = 0;
	int burst_left = 0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;

	sorted_min_priority_queue_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #HALF_PERIOD clk = ~clk;

	// Insert after any equal entries
	function automatic void shadow_insert(input logic signed [DATA_W-1:0] v);
		int p;
		p = 0;
		while (p < shadow_count && shadow_vals[p] <= v)
			p++;
		for (int i = shadow_count; i > p; i--)
			shadow_vals[i] = shadow_vals[i-1];
		shadow_vals[p] = v;
		shadow_count++;
	endfunction

	function automatic void shadow_remove(input int idx);
		for (int i = idx; i < shadow_count - 1; i++)
			shadow_vals[i] = shadow_vals[i+1];
		shadow_count--;
	endfunction

	function automatic int shadow_find(input logic signed [DATA_W-1:0] v);
		for (int i = 0; i < shadow_count; i++)
			if (shadow_vals[i] == v)
				return i;
		return -1;
	endfunction

	// Apply one operation to the shadow store and build its result
	function automatic pq_result_t predict_op(input logic [2:0] kind,
		input logic signed [DATA_W-1:0] v, input logic signed [DATA_W-1:0] nv);
		pq_result_t r;
		int idx;
		r = '0;
		case (kind)
			smpq_pkg::KIND_ENQ: begin
				if (shadow_count >= DEPTH)
					r.status = smpq_pkg::ST_FULL;
				else
					shadow_insert(v);
			end
			smpq_pkg::KIND_DEQ: begin
				if (shadow_count == 0) begin
					r.status = smpq_pkg::ST_EMPTY;
				end else begin
					r.removed = shadow_vals[0];
					shadow_remove(0);
				end
			end
			smpq_pkg::KIND_SEARCH: begin
				if (shadow_count == 0) begin
					r.status = smpq_pkg::ST_EMPTY;
				end else begin
					idx = shadow_find(v);
					if (idx >= 0)
						r.pos = CNT_W'(idx + 1);
					else
						r.status = smpq_pkg::ST_NOTFOUND;
				end
			end
			smpq_pkg::KIND_UPDATE: begin
				if (shadow_count == 0) begin
					r.status = smpq_pkg::ST_EMPTY;
				end else begin
					idx = shadow_find(v);
					if (idx >= 0) begin
						shadow_remove(idx);
						shadow_insert(nv);
					end else begin
						r.status = smpq_pkg::ST_NOTFOUND;
					end
				end
			end
			smpq_pkg::KIND_CLEAR: shadow_count = 0;
			default: ;
		endcase
		r.front = (shadow_count != 0) ? shadow_vals[0] : '0;
		r.occ = CNT_W'(shadow_count);
		r.empty = (shadow_count == 0);
		return r;
	endfunction

	function automatic pq_result_t mk_res(input logic [1:0] st, input logic [DATA_W-1:0] rem,
		input int pos, input logic [DATA_W-1:0] front, input int occ);
		pq_result_t r;
		r.status = st;
		r.removed = rem;
		r.pos = CNT_W'(pos);
		r.front = front;
		r.occ = CNT_W'(occ);
		r.empty = (occ == 0);
		return r;
	endfunction

	function automatic void add_row(input logic [2:0] kind, input logic [DATA_W-1:0] v,
		input logic [DATA_W-1:0] nv, input int reps, input bit typed, input pq_result_t res);
		dir_rows.push_back('{kind, v, nv, reps, typed, res});
	endfunction

	// Often stored values so search and update hit, plus small, extreme and wide values
	function automatic logic signed [DATA_W-1:0] pick_value();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel <= 3 && shadow_count > 0)
			return shadow_vals[$urandom_range(0, shadow_count - 1)];
		if (sel <= 6)
			return DATA_W'($signed($urandom_range(0, 16)) - 8);
		if (sel == 7) begin
			case ($urandom_range(0, 3))
				0: return MAXV;
				1: return MINV;
				2: return '0;
				default: return '1;
			endcase
		end
		return $urandom;
	endfunction

	// Offer one transaction, sometimes pausing between bursts; predict once accepted
	task automatic send_item(input logic [2:0] kind, input logic [DATA_W-1:0] v,
		input logic [DATA_W-1:0] nv, input bit typed, input pq_result_t res);
		int gap;
		pq_result_t r;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {nv, v};
		do
			@(posedge clk);
		while (!s_tready);
		r = predict_op(kind, v, nv);
		pending_results.push_back(typed ? res : r);
	endtask

	task automatic report_mismatch(input string field, input logic [DATA_W-1:0] got,
		input logic [DATA_W-1:0] want);
		$display("mismatch on result %0d, %s: got %h, want %h", result_idx, field, got, want);
		err_count++;
	endtask

	// Check every result transaction against the oldest expectation
	always @(posedge clk) begin
		pq_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", m_tdata[31:0], '0);
			end else begin
				want = pending_results.pop_front();
				if (m_tuser != want.status)
					report_mismatch("status", DATA_W'(m_tuser), DATA_W'(want.status));
				if (m_tdata[31:0] != want.removed)
					report_mismatch("removed_value", m_tdata[31:0], want.removed);
				if (m_tdata[36:32] != want.pos)
					report_mismatch("position", DATA_W'(m_tdata[36:32]), DATA_W'(want.pos));
				if (m_tdata[68:37] != want.front)
					report_mismatch("front_value", m_tdata[68:37], want.front);
				if (m_tdata[73:69] != want.occ)
					report_mismatch("occupancy", DATA_W'(m_tdata[73:69]), DATA_W'(want.occ));
				if (m_tdata[74] != want.empty)
					report_mismatch("empty_res", DATA_W'(m_tdata[74]), DATA_W'(want.empty));
			end
			result_idx++;
		end
	end

	// Receiver stall pattern, with one long hold-off to back up the input
	initial begin
		int span;
		int k;
		rx_mode_t mode;
		forever begin
			if (hold_req && !hold_done) begin
				m_tready <= 1'b0;
				for (k = 0; k < HOLD_CYCLES; k++)
					@(posedge clk);
				hold_done = 1'b1;
			end
			span = $urandom_range(10, 80);
			mode = rx_mode_t'($urandom_range(0, 2));
			for (k = 0; k < span; k++) begin
				case (mode)
					RX_STEADY: m_tready <= 1'b1;
					RX_CHOPPY: m_tready <= 1'($urandom_range(0, 1));
					default:   m_tready <= ($urandom_range(0, 3) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	// Watchdog
	initial begin
		int cyc;
		cyc = 0;
		while (cyc < CYCLE_LIMIT) begin
			@(posedge clk);
			cyc++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	// Stimulus
	initial begin
		int i;
		int r;
		int n;
		int sel;
		int rand_sent;
		logic [2:0] kind;

		// Empty queue, extremes, fill to full, hits and misses, spare codes and clears
		add_row(smpq_pkg::KIND_DEQ, '0, '0, 1, 1'b1,
			mk_res(smpq_pkg::ST_EMPTY, '0, 0, '0, 0));
		add_row(smpq_pkg::KIND_SEARCH, 32'd7, '0, 1, 1'b1,
			mk_res(smpq_pkg::ST_EMPTY, '0, 0, '0, 0));
		add_row(smpq_pkg::KIND_UPDATE, 32'd7, 32'd9, 1, 1'b1,
			mk_res(smpq_pkg::ST_EMPTY, '0, 0, '0, 0));
		add_row(KIND_SPARE_LO, '1, '1, 1, 1'b1, mk_res(smpq_pkg::ST_OK, '0, 0, '0, 0));
		add_row(smpq_pkg::KIND_ENQ, MAXV, '0, 1, 1'b1,
			mk_res(smpq_pkg::ST_OK, '0, 0, MAXV, 1));
		add_row(smpq_pkg::KIND_ENQ, MINV, '0, 1, 1'b1,
			mk_res(smpq_pkg::ST_OK, '0, 0, MINV, 2));
		add_row(smpq_pkg::KIND_ENQ, '0, '0, DEPTH - 2, 1'b0, '0);
		add_row(smpq_pkg::KIND_ENQ, 32'd1, '0, 1, 1'b1,
			mk_res(smpq_pkg::ST_FULL, '0, 0, MINV, DEPTH));
		add_row(smpq_pkg::KIND_SEARCH, '0, '0, 1, 1'b0, '0);
		add_row(smpq_pkg::KIND_SEARCH, MAXV, '0, 1, 1'b0, '0);
		add_row(smpq_pkg::KIND_UPDATE, '0, '1, 1, 1'b0, '0);
		add_row(smpq_pkg::KIND_UPDATE, 32'd12345, 32'd5, 1, 1'b0, '0);
		add_row(smpq_pkg::KIND_SEARCH, 32'd12345, '0, 1, 1'b0, '0);
		add_row(smpq_pkg::KIND_DEQ, '0, '0, 1, 1'b0, '0);
		add_row(KIND_SPARE_MID, 32'h5A5A_A5A5, 32'hA5A5_5A5A, 1, 1'b0, '0);
		add_row(KIND_SPARE_HI, '0, '0, 1, 1'b0, '0);
		add_row(smpq_pkg::KIND_CLEAR, '0, '0, 1, 1'b1,
			mk_res(smpq_pkg::ST_OK, '0, 0, '0, 0));
		add_row(smpq_pkg::KIND_CLEAR, '0, '0, 1, 1'b1,
			mk_res(smpq_pkg::ST_OK, '0, 0, '0, 0));

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			for (r = 0; r < dir_rows[i].reps; r++)
				send_item(dir_rows[i].kind, dir_rows[i].value, dir_rows[i].new_value,
					dir_rows[i].typed, dir_rows[i].res);

		// Random episodes: fill, drain, mixed traffic, noise, clear
		hold_req = 1'b1;
		rand_sent = 0;
		while (rand_sent < RAND_ITEMS) begin
			sel = $urandom_range(0, 9);
			if (sel <= 2) begin
				n = $urandom_range(4, DEPTH + 3);
				for (i = 0; i < n; i++)
					send_item(smpq_pkg::KIND_ENQ, pick_value(), $urandom, 1'b0, '0);
			end else if (sel <= 4) begin
				n = $urandom_range(2, DEPTH + 2);
				for (i = 0; i < n; i++)
					send_item(smpq_pkg::KIND_DEQ, $urandom, $urandom, 1'b0, '0);
			end else if (sel <= 7) begin
				n = $urandom_range(5, 20);
				for (i = 0; i < n; i++) begin
					r = $urandom_range(0, 11);
					if (r <= 3)
						kind = smpq_pkg::KIND_ENQ;
					else if (r <= 5)
						kind = smpq_pkg::KIND_DEQ;
					else if (r <= 8)
						kind = smpq_pkg::KIND_SEARCH;
					else if (r <= 10)
						kind = smpq_pkg::KIND_UPDATE;
					else
						kind = smpq_pkg::KIND_CLEAR;
					send_item(kind, pick_value(), pick_value(), 1'b0, '0);
				end
			end else if (sel == 8) begin
				n = $urandom_range(1, 6);
				for (i = 0; i < n; i++)
					send_item(3'($urandom_range(0, 7)), $urandom, $urandom, 1'b0, '0);
			end else begin
				n = 1;
				send_item(smpq_pkg::KIND_CLEAR, $urandom, $urandom, 1'b0, '0);
			end
			rand_sent += n;
		end
		s_tvalid <= 1'b0;

		// Drain outstanding results, then watch for strays
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/smpq_pkg.sv
hw/rtl/smpq_cell.sv
hw/rtl/sorted_min_priority_queue_core.sv
bench/sorted_min_priority_queue_core_tb.sv
